// ===== rtl/mhdc_pkg.sv =====
// Shared widths, payload types and register codes for the MHD conservative-to-primitive block.
package mhdc_pkg;

    // Word format: signed Q23.40
    localparam int WORD_W    = 64;
    localparam int FRAC_BITS = 40;
    localparam int HALF_W    = WORD_W / 2;

    // Squares and sums of squares
    localparam int SQ_W  = 2 * WORD_W;
    localparam int KSQ_W = SQ_W + 2;

    // Pipelined restoring divider: one quotient bit per stage
    localparam int QUOT_W    = 66;
    localparam int REM_W     = WORD_W;
    localparam int LANES     = 4;
    localparam int MOM_LANES = 3;
    localparam int KIN_LANE  = 3;

    // Energy balance and pressure product
    localparam int BSQ_SH_W = KSQ_W - FRAC_BITS - 1;
    localparam int NEGP_W   = BSQ_SH_W + 2;
    localparam int GAMMA_W  = 42;
    localparam int FLOOR_W  = 41;
    localparam int PART_W   = HALF_W + GAMMA_W;
    localparam int PROD_W   = WORD_W + GAMMA_W;
    localparam int PM_W     = PROD_W - FRAC_BITS;

    // Configuration port
    localparam int CFG_DATA_W  = GAMMA_W;
    localparam int CFG_INDEX_W = 2;

    // Front stages, divider stages and back stages
    localparam int DIV_LATENCY   = QUOT_W;
    localparam int TOTAL_LATENCY = DIV_LATENCY + 10;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET  = 42'd733007751851;
    localparam logic [FLOOR_W-1:0] DFLOOR_RESET = 41'd1;
    localparam logic [FLOOR_W-1:0] PFLOOR_RESET = 41'd1;

    localparam logic [WORD_W-1:0] SAT_POS     = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG_MAG = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ROUND_BIAS  = {{(WORD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic [WORD_W-1:0] MINUS_ONE   = {{(WORD_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [QUOT_W-1:0] KIN_CLAMP   = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAMMA          = 2'd0,
        CFG_DENSITY_FLOOR  = 2'd1,
        CFG_PRESSURE_FLOOR = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic signed [WORD_W-1:0] cons_density;
        logic signed [WORD_W-1:0] cons_mom_x;
        logic signed [WORD_W-1:0] cons_mom_y;
        logic signed [WORD_W-1:0] cons_mom_z;
        logic signed [WORD_W-1:0] cons_energy;
        logic signed [WORD_W-1:0] cons_field_x;
        logic signed [WORD_W-1:0] cons_field_y;
        logic signed [WORD_W-1:0] cons_field_z;
        logic signed [WORD_W-1:0] cons_cleaning;
    } cons_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] prim_density;
        logic signed [WORD_W-1:0] prim_vel_x;
        logic signed [WORD_W-1:0] prim_vel_y;
        logic signed [WORD_W-1:0] prim_vel_z;
        logic signed [WORD_W-1:0] prim_pressure;
        logic signed [WORD_W-1:0] prim_field_x;
        logic signed [WORD_W-1:0] prim_field_y;
        logic signed [WORD_W-1:0] prim_field_z;
        logic signed [WORD_W-1:0] prim_cleaning;
        logic                     is_physical_flag;
        logic                     bad_density_flag;
        logic                     overflow_flag;
    } prim_t;

    typedef logic [LANES-1:0][REM_W-1:0]  lane_rem_t;
    typedef logic [LANES-1:0][QUOT_W-1:0] lane_quot_t;

    // Fields that ride along with the divider
    typedef struct packed {
        logic [WORD_W-1:0]        rho;
        logic [WORD_W-1:0]        e_mag;
        logic                     e_neg;
        logic [BSQ_SH_W-1:0]      bsq_sh;
        logic signed [WORD_W-1:0] field_x;
        logic signed [WORD_W-1:0] field_y;
        logic signed [WORD_W-1:0] field_z;
        logic signed [WORD_W-1:0] cleaning;
        logic [MOM_LANES-1:0]     msign;
        logic [LANES-1:0]         top_ovf;
        logic                     bad;
    } side_t;

endpackage

// ===== rtl/mhdc_div_pipe.sv =====
// Four-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module mhdc_div_pipe
    import mhdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [REM_W-1:0]  divisor,
    input  lane_rem_t         rem_in,
    input  lane_quot_t        numer_in,
    input  side_t             side_in,
    output logic              out_valid,
    output lane_quot_t        quot_out,
    output side_t             side_out
);

    logic [QUOT_W-1:0] valid_reg;
    lane_rem_t         rem_reg  [QUOT_W];
    lane_quot_t        nq_reg   [QUOT_W];
    logic [REM_W-1:0]  div_reg  [QUOT_W];
    side_t             side_reg [QUOT_W];

    genvar k, l;
    for (k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic             src_valid;
        lane_rem_t        src_rem;
        lane_quot_t       src_nq;
        logic [REM_W-1:0] src_div;
        side_t            src_side;
        lane_rem_t        rem_next;
        lane_quot_t       nq_next;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = rem_in;
            assign src_nq    = numer_in;
            assign src_div   = divisor;
            assign src_side  = side_in;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_nq    = nq_reg[k-1];
            assign src_div   = div_reg[k-1];
            assign src_side  = side_reg[k-1];
        end

        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [REM_W:0] trial;
            logic           take;
            // bring down the next numerator bit, subtract when it fits
            assign trial = {src_rem[l], src_nq[l][QUOT_W-1]};
            assign take  = (trial >= {1'b0, src_div});
            assign rem_next[l] = take ? REM_W'(trial - {1'b0, src_div}) : trial[REM_W-1:0];
            assign nq_next[l]  = {src_nq[l][QUOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            nq_reg[k]   <= nq_next;
            div_reg[k]  <= src_div;
            side_reg[k] <= src_side;
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quot_out  = nq_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, DIV_LATENCY))
        else $error("divider output without matching input");

    a_rem_lane0: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[QUOT_W-2] && div_reg[QUOT_W-2] != '0 && !div_reg[QUOT_W-2][REM_W-1]
         && rem_reg[QUOT_W-2][0] < div_reg[QUOT_W-2])
        |=> rem_reg[QUOT_W-1][0] < div_reg[QUOT_W-1])
        else $error("lane 0 remainder escaped divisor");

    a_rem_kin: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[QUOT_W-2] && div_reg[QUOT_W-2] != '0 && !div_reg[QUOT_W-2][REM_W-1]
         && rem_reg[QUOT_W-2][KIN_LANE] < div_reg[QUOT_W-2])
        |=> rem_reg[QUOT_W-1][KIN_LANE] < div_reg[QUOT_W-1])
        else $error("kinetic lane remainder escaped divisor");
`endif

endmodule

// ===== rtl/mhd_conservative_to_primitive.sv =====
// Top level: pipelined ideal-MHD conservative-to-primitive conversion with GLM scalar.
//
//  port        dir  width            transfer
//  ----------  ---  ---------------  ---------------------------------------------
//  start/item  in   1 / cons_t       cell state taken at a clock edge with start high
//  done/result out  1 / prim_t       primitive state shown for one cycle with done
//  cfg_*       in   1 / 2 / 42       register write at a clock edge with cfg_we high
//
//  One cell enters every cycle; busy is always low. Each transfer passes through
//  ten arithmetic stages plus 66 stages of the shared-divisor divider, which
//  yields one quotient bit per stage.
//  Reset clears all stage valid bits and loads the register defaults.
//  There is no stall: the receiver takes every result in the cycle it shows.
module mhd_conservative_to_primitive
    import mhdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cons_t                  item,
    output logic                   done,
    output prim_t                  result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef struct packed {
        logic [WORD_W-1:0]                  rho;
        logic [WORD_W-1:0]                  e_mag;
        logic                               e_neg;
        logic signed [WORD_W-1:0]           field_x;
        logic signed [WORD_W-1:0]           field_y;
        logic signed [WORD_W-1:0]           field_z;
        logic signed [WORD_W-1:0]           cleaning;
        logic [MOM_LANES-1:0]               msign;
        logic [MOM_LANES-1:0][WORD_W-1:0]   mom_mag;
        logic                               bad;
    } carry_t;

    typedef struct packed {
        logic [WORD_W-1:0] ll;
        logic [WORD_W-1:0] lh;
        logic [WORD_W-1:0] hh;
    } sq_part_t;

    typedef struct packed {
        logic [MOM_LANES-1:0][WORD_W-1:0] vel;
        logic                             ovf;
        logic [WORD_W-1:0]                rho;
        logic signed [WORD_W-1:0]         field_x;
        logic signed [WORD_W-1:0]         field_y;
        logic signed [WORD_W-1:0]         field_z;
        logic signed [WORD_W-1:0]         cleaning;
        logic                             bad;
    } mid_t;

    function automatic logic [WORD_W-1:0] abs_mag(input logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? ((~x) + WORD_W'(1)) : x;
    endfunction

    // ---------------- configuration registers ----------------
    logic [GAMMA_W-1:0] gamma_reg;
    logic [FLOOR_W-1:0] dfloor_reg;
    logic [FLOOR_W-1:0] pfloor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg  <= GAMMA_RESET;
            dfloor_reg <= DFLOOR_RESET;
            pfloor_reg <= PFLOOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAMMA:          gamma_reg  <= cfg_data;
                CFG_DENSITY_FLOOR:  dfloor_reg <= cfg_data[FLOOR_W-1:0];
                CFG_PRESSURE_FLOOR: pfloor_reg <= cfg_data[FLOOR_W-1:0];
                default:            ;
            endcase
        end
    end

    // The pipeline takes a transfer every cycle.
    assign busy = 1'b0;

    // ---------------- stage valid bits ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, done_reg;
    logic dv_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= dv_valid;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            done_reg <= v9_reg;
        end
    end

    // ---------------- stage 1: capture the transfer ----------------
    cons_t in_reg;

    always_ff @(posedge clk)
    begin
        in_reg <= item;
    end

    // ---------------- stage 2: magnitudes and signs ----------------
    carry_t                           carry2_next, carry2_reg;
    logic [MOM_LANES-1:0][WORD_W-1:0] bmag2_next, bmag2_reg;

    always_comb
    begin
        carry2_next.rho        = in_reg.cons_density;
        carry2_next.e_mag      = abs_mag(in_reg.cons_energy);
        carry2_next.e_neg      = in_reg.cons_energy[WORD_W-1];
        carry2_next.field_x    = in_reg.cons_field_x;
        carry2_next.field_y    = in_reg.cons_field_y;
        carry2_next.field_z    = in_reg.cons_field_z;
        carry2_next.cleaning   = in_reg.cons_cleaning;
        carry2_next.msign      = {in_reg.cons_mom_z[WORD_W-1], in_reg.cons_mom_y[WORD_W-1],
                                  in_reg.cons_mom_x[WORD_W-1]};
        carry2_next.mom_mag[0] = abs_mag(in_reg.cons_mom_x);
        carry2_next.mom_mag[1] = abs_mag(in_reg.cons_mom_y);
        carry2_next.mom_mag[2] = abs_mag(in_reg.cons_mom_z);
        // density not positive
        carry2_next.bad        = in_reg.cons_density[WORD_W-1] || (in_reg.cons_density == '0);
        bmag2_next[0]          = abs_mag(in_reg.cons_field_x);
        bmag2_next[1]          = abs_mag(in_reg.cons_field_y);
        bmag2_next[2]          = abs_mag(in_reg.cons_field_z);
    end

    always_ff @(posedge clk)
    begin
        carry2_reg <= carry2_next;
        bmag2_reg  <= bmag2_next;
    end

    // ---------------- stage 3: 32x32 partial products of the squares ----------------
    // Entries 0..2 are momenta, 3..5 field components; the cross term appears twice.
    sq_part_t [2*MOM_LANES-1:0] pp3_next, pp3_reg;
    carry_t                     carry3_reg;

    always_comb
    begin
        logic [WORD_W-1:0] mag;
        for (int i = 0; i < 2 * MOM_LANES; i++)
        begin
            mag = (i < MOM_LANES) ? carry2_reg.mom_mag[i] : bmag2_reg[i - MOM_LANES];
            pp3_next[i].ll = WORD_W'(mag[HALF_W-1:0]) * WORD_W'(mag[HALF_W-1:0]);
            pp3_next[i].lh = WORD_W'(mag[HALF_W-1:0]) * WORD_W'(mag[WORD_W-1:HALF_W]);
            pp3_next[i].hh = WORD_W'(mag[WORD_W-1:HALF_W]) * WORD_W'(mag[WORD_W-1:HALF_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        pp3_reg    <= pp3_next;
        carry3_reg <= carry2_reg;
    end

    // ---------------- stage 4: assemble the squares ----------------
    logic [2*MOM_LANES-1:0][SQ_W-1:0] sq4_next, sq4_reg;
    carry_t                           carry4_reg;

    always_comb
    begin
        for (int i = 0; i < 2 * MOM_LANES; i++)
        begin
            sq4_next[i] = (SQ_W'(pp3_reg[i].hh) << WORD_W)
                        + (SQ_W'(pp3_reg[i].lh) << (HALF_W + 1))
                        + SQ_W'(pp3_reg[i].ll);
        end
    end

    always_ff @(posedge clk)
    begin
        sq4_reg    <= sq4_next;
        carry4_reg <= carry3_reg;
    end

    // ---------------- stage 5: |m|^2 and |B|^2 ----------------
    logic [KSQ_W-1:0] ksq5_next, ksq5_reg, bsq5_next, bsq5_reg;
    carry_t           carry5_reg;

    assign ksq5_next = KSQ_W'(sq4_reg[0]) + KSQ_W'(sq4_reg[1]) + KSQ_W'(sq4_reg[2]);
    assign bsq5_next = KSQ_W'(sq4_reg[3]) + KSQ_W'(sq4_reg[4]) + KSQ_W'(sq4_reg[5]);

    always_ff @(posedge clk)
    begin
        ksq5_reg   <= ksq5_next;
        bsq5_reg   <= bsq5_next;
        carry5_reg <= carry4_reg;
    end

    // ---------------- stage 6: divider setup ----------------
    // The numerator splits into a head (below the divisor unless the quotient
    // is too wide) and QUOT_W low bits shifted in one per divider stage.
    lane_rem_t        rem6_next, rem6_reg;
    lane_quot_t       num6_next, num6_reg;
    side_t            side6_next, side6_reg;
    logic [REM_W-1:0] divisor6_reg;

    always_comb
    begin
        for (int i = 0; i < MOM_LANES; i++)
        begin
            rem6_next[i] = REM_W'(carry5_reg.mom_mag[i] >> (QUOT_W - FRAC_BITS));
            num6_next[i] = {carry5_reg.mom_mag[i][QUOT_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
        rem6_next[KIN_LANE] = ksq5_reg[KSQ_W-1:QUOT_W];
        num6_next[KIN_LANE] = ksq5_reg[QUOT_W-1:0];

        side6_next.rho      = carry5_reg.rho;
        side6_next.e_mag    = carry5_reg.e_mag;
        side6_next.e_neg    = carry5_reg.e_neg;
        side6_next.bsq_sh   = bsq5_reg[KSQ_W-1:FRAC_BITS+1];
        side6_next.field_x  = carry5_reg.field_x;
        side6_next.field_y  = carry5_reg.field_y;
        side6_next.field_z  = carry5_reg.field_z;
        side6_next.cleaning = carry5_reg.cleaning;
        side6_next.msign    = carry5_reg.msign;
        side6_next.bad      = carry5_reg.bad;
        for (int i = 0; i < LANES; i++)
        begin
            side6_next.top_ovf[i] = (rem6_next[i] >= carry5_reg.rho);
        end
    end

    always_ff @(posedge clk)
    begin
        rem6_reg     <= rem6_next;
        num6_reg     <= num6_next;
        side6_reg    <= side6_next;
        divisor6_reg <= carry5_reg.rho;
    end

    // ---------------- divider ----------------
    lane_quot_t dv_quot;
    side_t      dv_side;

    mhdc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .divisor   (divisor6_reg),
        .rem_in    (rem6_reg),
        .numer_in  (num6_reg),
        .side_in   (side6_reg),
        .out_valid (dv_valid),
        .quot_out  (dv_quot),
        .side_out  (dv_side)
    );

    // ---------------- stage 7: velocities, energy to subtract ----------------
    mid_t              mid7_next, mid7_reg;
    logic [NEGP_W-1:0] negp7_next, negp7_reg;
    logic [WORD_W-1:0] pos7_next, pos7_reg;

    always_comb
    begin
        logic [QUOT_W-1:0] lim;
        logic [QUOT_W-1:0] kin;
        mid7_next.ovf = 1'b0;
        for (int i = 0; i < MOM_LANES; i++)
        begin
            lim = QUOT_W'(dv_side.msign[i] ? SAT_NEG_MAG : SAT_POS);
            if (dv_side.top_ovf[i] || dv_quot[i] > lim)
            begin
                mid7_next.vel[i] = lim[WORD_W-1:0];
                mid7_next.ovf    = 1'b1;
            end
            else
            begin
                mid7_next.vel[i] = dv_quot[i][WORD_W-1:0];
            end
            if (dv_side.msign[i])
            begin
                mid7_next.vel[i] = (~mid7_next.vel[i]) + WORD_W'(1);
            end
        end
        mid7_next.rho      = dv_side.rho;
        mid7_next.field_x  = dv_side.field_x;
        mid7_next.field_y  = dv_side.field_y;
        mid7_next.field_z  = dv_side.field_z;
        mid7_next.cleaning = dv_side.cleaning;
        mid7_next.bad      = dv_side.bad;

        // a clamped kinetic term is already far past any energy
        kin = dv_side.top_ovf[KIN_LANE] ? KIN_CLAMP : {1'b0, dv_quot[KIN_LANE][QUOT_W-1:1]};
        negp7_next = NEGP_W'(kin) + NEGP_W'(dv_side.bsq_sh)
                   + NEGP_W'(dv_side.e_neg ? dv_side.e_mag : '0);
        pos7_next  = dv_side.e_neg ? '0 : dv_side.e_mag;
    end

    always_ff @(posedge clk)
    begin
        mid7_reg  <= mid7_next;
        negp7_reg <= negp7_next;
        pos7_reg  <= pos7_next;
    end

    // ---------------- stage 8: internal energy, saturated ----------------
    mid_t              mid8_next, mid8_reg;
    logic [WORD_W-1:0] dm8_next, dm8_reg;
    logic              dneg8_next, dneg8_reg;

    always_comb
    begin
        logic [NEGP_W-1:0] pos_w;
        logic [NEGP_W-1:0] diff;
        logic [NEGP_W-1:0] lim;
        mid8_next  = mid7_reg;
        pos_w      = NEGP_W'(pos7_reg);
        dneg8_next = (pos_w < negp7_reg);
        diff       = dneg8_next ? (negp7_reg - pos_w) : (pos_w - negp7_reg);
        lim        = NEGP_W'(dneg8_next ? SAT_NEG_MAG : SAT_POS);
        if (diff > lim)
        begin
            dm8_next      = lim[WORD_W-1:0];
            mid8_next.ovf = 1'b1;
        end
        else
        begin
            dm8_next = diff[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mid8_reg  <= mid8_next;
        dm8_reg   <= dm8_next;
        dneg8_reg <= dneg8_next;
    end

    // ---------------- stage 9: energy times (gamma - 1), two halves ----------------
    mid_t              mid9_reg;
    logic [PART_W-1:0] plo9_reg, phi9_reg;
    logic              dneg9_reg;

    always_ff @(posedge clk)
    begin
        plo9_reg  <= PART_W'(dm8_reg[HALF_W-1:0]) * PART_W'(gamma_reg);
        phi9_reg  <= PART_W'(dm8_reg[WORD_W-1:HALF_W]) * PART_W'(gamma_reg);
        dneg9_reg <= dneg8_reg;
        mid9_reg  <= mid8_reg;
    end

    // ---------------- stage 10: pressure, flags, result ----------------
    prim_t result_next, result_reg;

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        logic [PM_W-1:0]   pm;
        logic [PM_W-1:0]   lim;
        logic [WORD_W-1:0] pmag;
        logic [WORD_W-1:0] pres;
        logic              pneg;
        logic              ovf;

        // negative values floor, so round the magnitude up
        prod = (PROD_W'(phi9_reg) << HALF_W) + PROD_W'(plo9_reg)
             + PROD_W'(dneg9_reg ? ROUND_BIAS : '0);
        pm   = prod[PROD_W-1:FRAC_BITS];
        pneg = dneg9_reg && (pm != '0);
        lim  = PM_W'(pneg ? SAT_NEG_MAG : SAT_POS);
        ovf  = mid9_reg.ovf;
        if (pm > lim)
        begin
            pmag = lim[WORD_W-1:0];
            ovf  = 1'b1;
        end
        else
        begin
            pmag = pm[WORD_W-1:0];
        end
        pres = pneg ? ((~pmag) + WORD_W'(1)) : pmag;

        result_next.prim_density  = mid9_reg.rho;
        result_next.prim_field_x  = mid9_reg.field_x;
        result_next.prim_field_y  = mid9_reg.field_y;
        result_next.prim_field_z  = mid9_reg.field_z;
        result_next.prim_cleaning = mid9_reg.cleaning;

        if (mid9_reg.bad)
        begin
            // drop velocities, report pressure as minus one
            result_next.prim_vel_x       = '0;
            result_next.prim_vel_y       = '0;
            result_next.prim_vel_z       = '0;
            result_next.prim_pressure    = MINUS_ONE;
            result_next.is_physical_flag = 1'b0;
            result_next.bad_density_flag = 1'b1;
            result_next.overflow_flag    = 1'b0;
        end
        else
        begin
            result_next.prim_vel_x       = mid9_reg.vel[0];
            result_next.prim_vel_y       = mid9_reg.vel[1];
            result_next.prim_vel_z       = mid9_reg.vel[2];
            result_next.prim_pressure    = pres;
            result_next.is_physical_flag = !ovf && (mid9_reg.rho > WORD_W'(dfloor_reg))
                                         && !pres[WORD_W-1] && (pres > WORD_W'(pfloor_reg));
            result_next.bad_density_flag = 1'b0;
            result_next.overflow_flag    = ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LATENCY))
        else $error("result without matching transfer");

    a_bad_density: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_density_flag) |->
        (result.prim_vel_x == '0 && result.prim_vel_y == '0 && result.prim_vel_z == '0
         && !result.overflow_flag && !result.is_physical_flag))
        else $error("bad density result not forced");

    a_physical: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_physical_flag) |->
        (!result.overflow_flag && !result.bad_density_flag
         && !result.prim_pressure[WORD_W-1] && result.prim_pressure != '0))
        else $error("physical flag with bad state");
`endif

endmodule

// ===== sim/tb_mhd_conservative_to_primitive.sv =====
// Self-checking testbench for the MHD conservative-to-primitive conversion block.
module tb_mhd_conservative_to_primitive
    import mhdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    cons_t                  item;
    logic                   done;
    prim_t                  result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Our own copy of the configuration registers
    logic [GAMMA_W-1:0] gamma_q;
    logic [FLOOR_W-1:0] dfloor_q;
    logic [FLOOR_W-1:0] pfloor_q;

    // Primitive states predicted for accepted cells, oldest first
    prim_t pending_prim[$];
    int    errors;

    mhd_conservative_to_primitive u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clamp a sign/magnitude value to the signed word range.
    // Return the two's complement word; give back the clamped magnitude too.
    function automatic logic [WORD_W-1:0] clamp_word(input bit neg, input bit [131:0] m,
                                                     inout bit ovf,
                                                     output logic [WORD_W-1:0] mag);
        bit [131:0] limit;
        limit = neg ? 132'h8000_0000_0000_0000 : 132'h7FFF_FFFF_FFFF_FFFF;
        if (m > limit)
        begin
            m   = limit;
            ovf = 1'b1;
        end
        mag = m[WORD_W-1:0];
        return neg ? -m[WORD_W-1:0] : m[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? -x : x;
    endfunction

    // Predict the primitive state of one cell under the current registers.
    function automatic prim_t prim_from_cons(input cons_t c);
        prim_t             p;
        logic [WORD_W-1:0] rho, am, ab, dm, unused_mag, pres;
        logic [WORD_W-1:0] mom[3];
        logic [WORD_W-1:0] fld[3];
        logic [WORD_W-1:0] vel[3];
        bit [131:0]        ksq, bsq, kin, negp, pos, diff, prod, pm;
        bit                ovf, dneg;
        rho    = c.cons_density;
        mom[0] = c.cons_mom_x;
        mom[1] = c.cons_mom_y;
        mom[2] = c.cons_mom_z;
        fld[0] = c.cons_field_x;
        fld[1] = c.cons_field_y;
        fld[2] = c.cons_field_z;
        ovf    = 1'b0;
        p      = '0;
        p.prim_density  = c.cons_density;
        p.prim_field_x  = c.cons_field_x;
        p.prim_field_y  = c.cons_field_y;
        p.prim_field_z  = c.cons_field_z;
        p.prim_cleaning = c.cons_cleaning;
        if (rho[WORD_W-1] || rho == '0)
        begin
            // Non-positive density: zero velocity, pressure of minus one, no overflow
            p.prim_pressure    = MINUS_ONE;
            p.bad_density_flag = 1'b1;
            return p;
        end
        ksq = '0;
        bsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            am     = abs_word(mom[i]);
            ab     = abs_word(fld[i]);
            vel[i] = clamp_word(mom[i][WORD_W-1], (132'(am) << FRAC_BITS) / 132'(rho),
                                ovf, unused_mag);
            ksq    = ksq + 132'(am) * 132'(am);
            bsq    = bsq + 132'(ab) * 132'(ab);
        end
        kin  = (ksq / 132'(rho)) >> 1;
        negp = kin + (bsq >> (FRAC_BITS + 1));
        pos  = '0;
        if (c.cons_energy[WORD_W-1])
            negp = negp + 132'(abs_word(c.cons_energy));
        else
            pos = 132'(c.cons_energy);
        dneg = pos < negp;
        diff = dneg ? negp - pos : pos - negp;
        void'(clamp_word(dneg, diff, ovf, dm));
        prod = 132'(dm) * 132'(gamma_q);
        // Negative differences round toward minus infinity on the magnitude side
        pm   = dneg ? (prod + 132'(ROUND_BIAS)) >> FRAC_BITS : prod >> FRAC_BITS;
        pres = clamp_word(dneg && pm != 0, pm, ovf, unused_mag);
        p.prim_vel_x       = vel[0];
        p.prim_vel_y       = vel[1];
        p.prim_vel_z       = vel[2];
        p.prim_pressure    = pres;
        p.overflow_flag    = ovf;
        p.is_physical_flag = !ovf && rho > 64'(dfloor_q) && !pres[WORD_W-1]
                             && pres > 64'(pfloor_q);
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, exp_v, act_v);
        end
    endfunction

    // Compare every result with the oldest prediction
    always @(posedge clk)
    begin
        prim_t e;
        if (rst_n && done === 1'b1)
        begin
            if (pending_prim.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $realtime, result);
            end
            else
            begin
                e = pending_prim.pop_front();
                check_field("prim_density", e.prim_density, result.prim_density);
                check_field("prim_vel_x", e.prim_vel_x, result.prim_vel_x);
                check_field("prim_vel_y", e.prim_vel_y, result.prim_vel_y);
                check_field("prim_vel_z", e.prim_vel_z, result.prim_vel_z);
                check_field("prim_pressure", e.prim_pressure, result.prim_pressure);
                check_field("prim_field_x", e.prim_field_x, result.prim_field_x);
                check_field("prim_field_y", e.prim_field_y, result.prim_field_y);
                check_field("prim_field_z", e.prim_field_z, result.prim_field_z);
                check_field("prim_cleaning", e.prim_cleaning, result.prim_cleaning);
                check_field("is_physical_flag", 64'(e.is_physical_flag),
                            64'(result.is_physical_flag));
                check_field("bad_density_flag", 64'(e.bad_density_flag),
                            64'(result.bad_density_flag));
                check_field("overflow_flag", 64'(e.overflow_flag), 64'(result.overflow_flag));
            end
        end
    end

    // Drive one cell and hold it until the transfer; leave start high so that a
    // back-to-back cell needs no second assignment in the same step.
    task automatic send_cell(input cons_t c);
        @(negedge clk);
        start = 1'b1;
        item  = c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_prim.push_back(prim_from_cons(c));
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Insert a random burst of idle cycles now and then
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 10));
    endtask

    // Hold off the sender until every prediction has been met, then let the
    // pipeline run empty.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        wait (pending_prim.size() == 0);
        repeat (TOTAL_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        case (idx)
            CFG_GAMMA:          gamma_q  = data[GAMMA_W-1:0];
            CFG_DENSITY_FLOOR:  dfloor_q = data[FLOOR_W-1:0];
            CFG_PRESSURE_FLOOR: pfloor_q = data[FLOOR_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Signed value of a random bit length, so magnitudes spread across the range
    function automatic logic [WORD_W-1:0] scaled_word(input int bits);
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        v = (bits == 0) ? '0 : v >> (WORD_W - bits);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic cons_t random_cell();
        cons_t c;
        int    kind;
        kind = $urandom_range(0, 19);
        if (kind < 3)
            // Noise: every bit of every field at random
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            // Plausible cell: density near one (some of random sign or tiny), moderate flow and field
            c.cons_density  = {$urandom, $urandom} >> $urandom_range(18, 40);
            c.cons_mom_x    = scaled_word($urandom_range(0, 48));
            c.cons_mom_y    = scaled_word($urandom_range(0, 48));
            c.cons_mom_z    = scaled_word($urandom_range(0, 48));
            c.cons_energy   = scaled_word($urandom_range(30, 60));
            if ($urandom_range(0, 3) != 0)
                c.cons_energy = abs_word(c.cons_energy);
            c.cons_field_x  = scaled_word($urandom_range(0, 46));
            c.cons_field_y  = scaled_word($urandom_range(0, 46));
            c.cons_field_z  = scaled_word($urandom_range(0, 46));
            c.cons_cleaning = scaled_word($urandom_range(0, 64));
            if (kind == 3)
                c.cons_density = -scaled_word($urandom_range(0, 64));
            else if (kind == 4)
                c.cons_density = 64'($urandom_range(0, 3));
        end
        return c;
    endfunction

    task automatic test_directed();
        cons_t c;
        logic [WORD_W-1:0] one;
        one = 64'd1 << FRAC_BITS;
        // Quiet cell at rest with unit density and energy
        c = '0;
        c.cons_density = one;
        c.cons_energy  = one;
        send_cell(c);
        // Zero, negative and most negative density
        c.cons_density = '0;
        c.cons_mom_x   = one;
        send_cell(c);
        c.cons_density = -one;
        send_cell(c);
        c.cons_density = SAT_NEG_MAG;
        send_cell(c);
        // Smallest density with large momenta: velocities saturate both ways
        c.cons_density = 64'd1;
        c.cons_mom_x   = SAT_POS;
        c.cons_mom_y   = SAT_NEG_MAG;
        c.cons_mom_z   = -one;
        send_cell(c);
        // Largest density with extreme everything
        c.cons_density  = SAT_POS;
        c.cons_energy   = SAT_POS;
        c.cons_field_x  = SAT_NEG_MAG;
        c.cons_field_y  = SAT_POS;
        c.cons_field_z  = SAT_NEG_MAG;
        c.cons_cleaning = SAT_NEG_MAG;
        send_cell(c);
        // Negative energy: negative pressure
        c = '0;
        c.cons_density = one;
        c.cons_energy  = -one;
        send_cell(c);
        c.cons_energy  = SAT_NEG_MAG;
        c.cons_field_x = SAT_POS;
        send_cell(c);
        // Magnetic energy swamps total energy
        c.cons_energy  = one;
        c.cons_field_x = one << 2;
        send_cell(c);
        // Pressure at and just above the floor
        c = '0;
        c.cons_density = 64'd2;
        c.cons_energy  = 64'd2;
        send_cell(c);
        c.cons_energy  = 64'd3;
        send_cell(c);
        c.cons_density = 64'd1;
        c.cons_energy  = one;
        send_cell(c);
        // Huge positive energy: pressure saturates when the gamma register is above one
        c.cons_density  = one;
        c.cons_energy   = SAT_POS;
        c.cons_cleaning = SAT_POS;
        send_cell(c);
        drain();
    endtask

    task automatic test_random(input int n, input bit allow_idle);
        for (int i = 0; i < n; i++)
        begin
            send_cell(random_cell());
            maybe_idle(allow_idle);
        end
    endtask

    // Sweep registers through extremes, with traffic between the writes
    task automatic test_registers();
        write_reg(CFG_GAMMA, '0);
        write_reg(CFG_DENSITY_FLOOR, '0);
        write_reg(CFG_PRESSURE_FLOOR, '0);
        test_directed();
        test_random(150, 1'b1);
        drain();
        write_reg(CFG_GAMMA, 42'd2199023255552);
        write_reg(CFG_DENSITY_FLOOR, 42'd1099511627776);
        write_reg(CFG_PRESSURE_FLOOR, 42'd1099511627776);
        test_random(150, 1'b1);
        drain();
        // All ones: gamma above its range, floors masked to their width
        write_reg(CFG_GAMMA, '1);
        write_reg(CFG_DENSITY_FLOOR, '1);
        write_reg(CFG_PRESSURE_FLOOR, '1);
        test_directed();
        test_random(150, 1'b1);
        drain();
        write_reg(CFG_GAMMA, 42'(($urandom_range(1, 2000) * 64'd1099511627776) / 1000));
        write_reg(CFG_DENSITY_FLOOR, 42'({$urandom, $urandom} >> 30));
        write_reg(CFG_PRESSURE_FLOOR, 42'({$urandom, $urandom} >> 30));
        test_random(200, 1'b1);
        drain();
        write_reg(CFG_GAMMA, GAMMA_RESET);
        write_reg(CFG_DENSITY_FLOOR, CFG_DATA_W'(DFLOOR_RESET));
        write_reg(CFG_PRESSURE_FLOOR, CFG_DATA_W'(PFLOOR_RESET));
    endtask

    initial
    begin
        errors    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GAMMA;
        cfg_data  = '0;
        gamma_q   = GAMMA_RESET;
        dfloor_q  = DFLOOR_RESET;
        pfloor_q  = PFLOOR_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values first, then the register sweep, then a long stream
        test_directed();
        test_random(300, 1'b1);
        drain();
        test_registers();
        test_random(250, 1'b1);
        // Last stretch: back-to-back transfers with no idling
        test_random(150, 1'b0);
        drain();

        if (errors == 0)
            $display("tb_mhd_conservative_to_primitive OK");
        else
            $display("tb_mhd_conservative_to_primitive NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_mhd_conservative_to_primitive NOT OK");
        $finish;
    end

endmodule
